// ----- hw/rtl/gwr_pkg.sv -----
// gwr_pkg: widths, constants, calendar tables and shared types for the
// gregorian weekday pipeline; no dependencies
`timescale 1ns / 1ps

package gwr_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int DIST_W  = 22;

   localparam int MAX_YEAR = 9999;

   // signed day number, from -1 up to a little above 3.65 million
   localparam int DNUM_W = 24;
   localparam int DIFF_W = DNUM_W + 1;

   localparam int DAYS_PER_YEAR = 365;
   localparam int DAYS_PER_WEEK = 7;
   localparam int CENTURY_DIV   = 25;

   localparam int MSTART_W = 9;
   localparam int LEXTRA_W = 2;

   // divide by 25 through a reciprocal, exact for 12-bit operands
   localparam int DIV25_SHIFT = 20;
   localparam int DIV25_MUL   = (2 ** DIV25_SHIFT + CENTURY_DIV - 1) / CENTURY_DIV;
   localparam int DIV25_MUL_W = 16;
   localparam int DIV25_IN_W  = YEAR_W - 2;
   localparam int PROD25_W    = DIV25_IN_W + DIV25_MUL_W;
   localparam int Q25_W       = PROD25_W - DIV25_SHIFT;

   // divide by 7 through a reciprocal, exact for 24-bit operands
   localparam int DIV7_SHIFT = 26;
   localparam int DIV7_MUL   = (2 ** DIV7_SHIFT + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;
   localparam int DIV7_MUL_W = 24;
   localparam int PROD7_W    = DNUM_W + DIV7_MUL_W;
   localparam int Q7_W       = PROD7_W - DIV7_SHIFT;

   localparam logic [DIST_W-1:0] DAYS_APART_MAX = {DIST_W{1'b1}};

   localparam int LANE_DEPTH = 6;

   typedef struct packed {
      logic signed [DNUM_W-1:0] num;
      logic [WDAY_W-1:0]        mod7;
   } dnum_type;

   // days before month m in a common year, months 13 to 15 count as february
   function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         4'd13:   r = 9'd365;
         4'd14:   r = 9'd393;
         4'd15:   r = 9'd421;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // elapsed februaries before month m
   function automatic logic [LEXTRA_W-1:0] leap_extra(input logic [MONTH_W-1:0] m);
      logic [LEXTRA_W-1:0] r;
      case (m) inside
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd14:            r = 2'd2;
         4'd15:            r = 2'd3;
         default:          r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/gwr_day_number.sv -----
// gwr_day_number: six-stage pipeline turning one date into its day number
// and the day number's residue modulo 7; uses gwr_pkg
`timescale 1ns / 1ps

module gwr_day_number (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [gwr_pkg::YEAR_W-1:0]    year,
   input  logic [gwr_pkg::MONTH_W-1:0]   month,
   input  logic [gwr_pkg::DAY_W-1:0]     day,
   output gwr_pkg::dnum_type             result
);

   localparam int YW = gwr_pkg::YEAR_W;
   localparam int XW = gwr_pkg::DIV25_IN_W;
   localparam int PW = gwr_pkg::PROD25_W;
   localparam int QW = gwr_pkg::Q25_W;
   localparam int NW = gwr_pkg::DNUM_W;
   localparam int P365_W = YW + 9;

   // stage 1: saturate year, elapsed years
   logic [YW-1:0]                  s1_p_ff,     s1_p_in;
   logic [YW-1:0]                  s1_y_ff,     s1_y_in;
   logic [gwr_pkg::MONTH_W-1:0]    s1_month_ff;
   logic [gwr_pkg::DAY_W-1:0]      s1_day_ff;

   // stage 2: reciprocal products for the divisions by 25
   logic [PW-1:0]                  s2_pp4_ff,   s2_pp4_in;
   logic [PW-1:0]                  s2_pp16_ff,  s2_pp16_in;
   logic [PW-1:0]                  s2_py4_ff,   s2_py4_in;
   logic [PW-1:0]                  s2_py16_ff,  s2_py16_in;
   logic [YW-1:0]                  s2_p_ff;
   logic [YW-1:0]                  s2_y_ff;
   logic [gwr_pkg::MONTH_W-1:0]    s2_month_ff;
   logic [gwr_pkg::DAY_W-1:0]      s2_day_ff;

   // stage 3: leap flag and year terms
   logic                           s3_leap_ff,  s3_leap_in;
   logic [QW-1:0]                  s3_q100_ff,  s3_q100_in;
   logic [QW-1:0]                  s3_q400_ff,  s3_q400_in;
   logic [P365_W-1:0]              s3_p365_ff,  s3_p365_in;
   logic [XW-1:0]                  s3_p4_ff,    s3_p4_in;
   logic [gwr_pkg::MONTH_W-1:0]    s3_month_ff;
   logic [gwr_pkg::DAY_W-1:0]      s3_day_ff;

   // stage 4: day number
   logic signed [NW-1:0]           s4_num_ff,   s4_num_in;

   // stage 5: reciprocal product for modulo 7
   logic [gwr_pkg::PROD7_W-1:0]    s5_prod_ff,  s5_prod_in;
   logic [NW-1:0]                  s5_mm_ff,    s5_mm_in;
   logic signed [NW-1:0]           s5_num_ff;

   // stage 6: residue
   gwr_pkg::dnum_type              s6_res_ff,   s6_res_in;

   logic [XW-1:0]                  y4_q, y16_q;
   logic [QW-1:0]                  qy4, qy16;
   logic [gwr_pkg::Q7_W-1:0]       q7;

   always_comb begin
      s1_y_in = year;
      if (32'(year) > gwr_pkg::MAX_YEAR) begin
         s1_y_in = YW'(gwr_pkg::MAX_YEAR);
      end
      s1_p_in = (s1_y_in == '0) ? '0 : s1_y_in - YW'(1);
   end

   always_comb begin
      s2_pp4_in  = PW'(XW'(s1_p_ff >> 2)) * PW'(gwr_pkg::DIV25_MUL);
      s2_pp16_in = PW'(XW'(s1_p_ff >> 4)) * PW'(gwr_pkg::DIV25_MUL);
      s2_py4_in  = PW'(XW'(s1_y_ff >> 2)) * PW'(gwr_pkg::DIV25_MUL);
      s2_py16_in = PW'(XW'(s1_y_ff >> 4)) * PW'(gwr_pkg::DIV25_MUL);
   end

   always_comb begin
      y4_q       = XW'(s2_y_ff >> 2);
      y16_q      = XW'(s2_y_ff >> 4);
      qy4        = s2_py4_ff[PW-1:gwr_pkg::DIV25_SHIFT];
      qy16       = s2_py16_ff[PW-1:gwr_pkg::DIV25_SHIFT];
      s3_q100_in = s2_pp4_ff[PW-1:gwr_pkg::DIV25_SHIFT];
      s3_q400_in = s2_pp16_ff[PW-1:gwr_pkg::DIV25_SHIFT];
      s3_leap_in = ((s2_y_ff[1:0] == 2'b00) &&
                    (y4_q != XW'(XW'(qy4) * XW'(gwr_pkg::CENTURY_DIV)))) ||
                   ((s2_y_ff[3:0] == 4'b0000) &&
                    (y16_q == XW'(XW'(qy16) * XW'(gwr_pkg::CENTURY_DIV))));
      s3_p365_in = P365_W'(s2_p_ff) * P365_W'(gwr_pkg::DAYS_PER_YEAR);
      s3_p4_in   = XW'(s2_p_ff >> 2);
   end

   always_comb begin
      s4_num_in = $signed(NW'(s3_p365_ff)) + $signed(NW'(s3_p4_ff))
                - $signed(NW'(s3_q100_ff)) + $signed(NW'(s3_q400_ff))
                + $signed(NW'(gwr_pkg::month_start(s3_month_ff)))
                + (s3_leap_ff ? $signed(NW'(gwr_pkg::leap_extra(s3_month_ff))) : '0)
                + $signed(NW'(s3_day_ff)) - NW'(1);
   end

   always_comb begin
      s5_mm_in   = NW'(s4_num_ff + NW'(gwr_pkg::DAYS_PER_WEEK));
      s5_prod_in = gwr_pkg::PROD7_W'(s5_mm_in) * gwr_pkg::PROD7_W'(gwr_pkg::DIV7_MUL);
   end

   always_comb begin
      q7             = s5_prod_ff[gwr_pkg::PROD7_W-1:gwr_pkg::DIV7_SHIFT];
      s6_res_in.num  = s5_num_ff;
      s6_res_in.mod7 = gwr_pkg::WDAY_W'(s5_mm_ff - NW'(NW'(q7) * NW'(gwr_pkg::DAYS_PER_WEEK)));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_p_ff     <= s1_p_in;
         s1_y_ff     <= s1_y_in;
         s1_month_ff <= month;
         s1_day_ff   <= day;

         s2_pp4_ff   <= s2_pp4_in;
         s2_pp16_ff  <= s2_pp16_in;
         s2_py4_ff   <= s2_py4_in;
         s2_py16_ff  <= s2_py16_in;
         s2_p_ff     <= s1_p_ff;
         s2_y_ff     <= s1_y_ff;
         s2_month_ff <= s1_month_ff;
         s2_day_ff   <= s1_day_ff;

         s3_leap_ff  <= s3_leap_in;
         s3_q100_ff  <= s3_q100_in;
         s3_q400_ff  <= s3_q400_in;
         s3_p365_ff  <= s3_p365_in;
         s3_p4_ff    <= s3_p4_in;
         s3_month_ff <= s2_month_ff;
         s3_day_ff   <= s2_day_ff;

         s4_num_ff   <= s4_num_in;

         s5_prod_ff  <= s5_prod_in;
         s5_mm_ff    <= s5_mm_in;
         s5_num_ff   <= s4_num_ff;

         s6_res_ff   <= s6_res_in;
      end
   end

   assign result = s6_res_ff;

endmodule

// ----- hw/rtl/gregorian_weekday_from_reference.sv -----
// gregorian_weekday_from_reference: top level, two day-number lanes and the
// distance and weekday output stage; uses gwr_pkg and gwr_day_number
`timescale 1ns / 1ps

// Every transfer carries two dates and the weekday of the first. The result
// (absolute day distance and weekday of the second date) passes through six
// stages in each day-number lane (year saturation, reciprocal divides by 25,
// leap and year terms, day sum, reciprocal divide by 7, residue) and one
// output register. One request is taken every cycle while req_stall is
// low. While a result sits in the output register under rsp_stall, the
// whole pipeline holds and req_stall is raised. No reset of the datapath
// is needed; reset only clears the valid bits.

module gregorian_weekday_from_reference (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gwr_pkg::YEAR_W-1:0]    req_first_year,
   input  logic [gwr_pkg::MONTH_W-1:0]   req_first_month,
   input  logic [gwr_pkg::DAY_W-1:0]     req_first_day,
   input  logic [gwr_pkg::YEAR_W-1:0]    req_second_year,
   input  logic [gwr_pkg::MONTH_W-1:0]   req_second_month,
   input  logic [gwr_pkg::DAY_W-1:0]     req_second_day,
   input  logic [gwr_pkg::WDAY_W-1:0]    req_first_weekday,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gwr_pkg::DIST_W-1:0]    rsp_days_apart,
   output logic [gwr_pkg::WDAY_W-1:0]    rsp_second_weekday
);

   localparam int DEPTH = gwr_pkg::LANE_DEPTH;
   localparam int WW    = gwr_pkg::WDAY_W;
   localparam int DW    = gwr_pkg::DIFF_W;

   logic                          enable;
   logic [DEPTH-1:0]              valid_ff, valid_in;
   logic [WW-1:0]                 wday_ff [DEPTH];
   logic [WW-1:0]                 wday_in;
   gwr_pkg::dnum_type             first_res, second_res;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gwr_pkg::DIST_W-1:0]    rsp_dist_ff,  rsp_dist_in;
   logic [WW-1:0]                 rsp_wday_ff,  rsp_wday_in;

   logic signed [DW-1:0]          diff;
   logic [DW-1:0]                 abs_diff;
   logic signed [WW+1:0]          wsum;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   gwr_day_number u_first (
      .clock  (clock),
      .enable (enable),
      .year   (req_first_year),
      .month  (req_first_month),
      .day    (req_first_day),
      .result (first_res)
   );

   gwr_day_number u_second (
      .clock  (clock),
      .enable (enable),
      .year   (req_second_year),
      .month  (req_second_month),
      .day    (req_second_day),
      .result (second_res)
   );

   always_comb begin
      wday_in  = (req_first_weekday == WW'(gwr_pkg::DAYS_PER_WEEK)) ? '0 : req_first_weekday;
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
   end

   // distance, saturation and weekday shift
   always_comb begin
      diff = DW'(second_res.num) - DW'(first_res.num);
      abs_diff = (diff < 0) ? DW'(-diff) : DW'(diff);
      if (abs_diff > DW'(gwr_pkg::DAYS_APART_MAX)) begin
         rsp_dist_in = gwr_pkg::DAYS_APART_MAX;
      end else begin
         rsp_dist_in = gwr_pkg::DIST_W'(abs_diff);
      end
      wsum = $signed({2'b00, wday_ff[DEPTH-1]}) + $signed({2'b00, second_res.mod7})
           - $signed({2'b00, first_res.mod7});
      if (wsum < 0) begin
         wsum = wsum + (WW+2)'(gwr_pkg::DAYS_PER_WEEK);
      end else if (wsum >= (WW+2)'(gwr_pkg::DAYS_PER_WEEK)) begin
         wsum = wsum - (WW+2)'(gwr_pkg::DAYS_PER_WEEK);
      end
      rsp_wday_in  = WW'(wsum);
      rsp_valid_in = valid_ff[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         wday_ff[0] <= wday_in;
         for (int i = 1; i < DEPTH; i++) begin
            wday_ff[i] <= wday_ff[i-1];
         end
         rsp_dist_ff <= rsp_dist_in;
         rsp_wday_ff <= rsp_wday_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_days_apart     = rsp_dist_ff;
   assign rsp_second_weekday = rsp_wday_ff;

endmodule

// ----- hw/rtl/gwr_checker.sv -----
// gwr_checker: port-level assertions for the gregorian weekday block and the
// bind that attaches them; uses gwr_pkg
`timescale 1ns / 1ps

module gwr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gwr_pkg::DIST_W-1:0]    rsp_days_apart,
   input logic [gwr_pkg::WDAY_W-1:0]    rsp_second_weekday
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_days_apart)
                                 && $stable(rsp_second_weekday))
      else $error("result changed while stalled");

   // backpressure only comes from a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // weekday stays reduced
   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second_weekday != gwr_pkg::WDAY_W'(gwr_pkg::DAYS_PER_WEEK))
      else $error("weekday out of range");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gregorian_weekday_from_reference gwr_checker u_gwr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_days_apart     (rsp_days_apart),
   .rsp_second_weekday (rsp_second_weekday)
);
